// ===== hw/rtl/ppt_pkg.sv =====
`default_nettype none

package ppt_pkg;

  // Field widths of the request and response words.
  localparam int unsigned MODE_BITS   = 2;
  localparam int unsigned ID_BITS     = 4;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned PRIO_BITS   = 16;
  localparam int unsigned STATUS_BITS = 2;

  localparam int unsigned ENTRIES_DEFAULT = 16;

  localparam logic [PRIO_BITS-1:0] PRIO_MAX = '1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD     = 2'd0,
    MODE_PROMOTE = 2'd1,
    MODE_POP     = 2'd2,
    MODE_READ    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOT_LIVE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // Per-cell commands from the controller.
  typedef struct packed {
    logic wr;       // store a new entry at level zero
    logic promote;  // raise the level by one if live
    logic clear;    // remove the entry
    logic sel;      // entry addressed by the current word
  } cell_ctrl_t;

  // Running result handed from cell to cell: the two best live entries seen
  // so far and the contents of the addressed entry. Ids travel beside it.
  typedef struct packed {
    logic                  best_vld;
    logic [PRIO_BITS-1:0]  best_lvl;
    logic [VALUE_BITS-1:0] best_val;
    logic                  sec_vld;
    logic [PRIO_BITS-1:0]  sec_lvl;
    logic [VALUE_BITS-1:0] sec_val;
    logic                  hit_live;
    logic [PRIO_BITS-1:0]  hit_lvl;
    logic [VALUE_BITS-1:0] hit_val;
  } link_t;

  localparam link_t LINK_EMPTY = '0;

  typedef struct packed {
    status_e               status;
    logic [ID_BITS-1:0]    result_id;
    logic [VALUE_BITS-1:0] result_value;
    logic [PRIO_BITS-1:0]  result_priority;
    logic                  result_live;
    logic                  max_present;
    logic [ID_BITS-1:0]    max_id;
    logic [VALUE_BITS-1:0] max_value;
    logic [PRIO_BITS-1:0]  max_priority;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppt_req_if.sv =====
`default_nettype none

interface ppt_req_if;
  import ppt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_BITS-1:0]  mode;
  logic [ID_BITS-1:0]    entry_id;
  logic [VALUE_BITS-1:0] item_value;

  modport source (output valid, output mode, output entry_id, output item_value,
                  input ready);
  modport sink   (input valid, input mode, input entry_id, input item_value,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ppt_rsp_if.sv =====
`default_nettype none

interface ppt_rsp_if;
  import ppt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [ID_BITS-1:0]     result_id;
  logic [VALUE_BITS-1:0]  result_value;
  logic [PRIO_BITS-1:0]   result_priority;
  logic                   result_live;
  logic                   max_present;
  logic [ID_BITS-1:0]     max_id;
  logic [VALUE_BITS-1:0]  max_value;
  logic [PRIO_BITS-1:0]   max_priority;

  modport source (output valid, output status, output result_id, output result_value,
                  output result_priority, output result_live, output max_present,
                  output max_id, output max_value, output max_priority,
                  input ready);
  modport sink   (input valid, input status, input result_id, input result_value,
                  input result_priority, input result_live, input max_present,
                  input max_id, input max_value, input max_priority,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ppt_cell.sv =====
`default_nettype none

module ppt_cell #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppt_pkg::cell_ctrl_t           ctrl_i,
  input  logic [ppt_pkg::VALUE_BITS-1:0] wr_value_i,
  input  ppt_pkg::link_t                link_i,
  input  logic [IDX_W-1:0]              best_id_i,
  input  logic [IDX_W-1:0]              sec_id_i,
  output ppt_pkg::link_t                link_o,
  output logic [IDX_W-1:0]              best_id_o,
  output logic [IDX_W-1:0]              sec_id_o
);
  import ppt_pkg::*;

  localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_IDX);

  logic [VALUE_BITS-1:0] val_q;
  logic [PRIO_BITS-1:0]  lvl_q;
  logic                  live_q;

  link_t            link_d, link_q;
  logic [IDX_W-1:0] best_id_d, best_id_q;
  logic [IDX_W-1:0] sec_id_d, sec_id_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      val_q <= wr_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
      lvl_q  <= '0;
    end else if (ctrl_i.wr) begin
      live_q <= 1'b1;
      lvl_q  <= '0;
    end else if (ctrl_i.clear) begin
      live_q <= 1'b0;
      lvl_q  <= '0;
    end else if (ctrl_i.promote && live_q && (lvl_q != PRIO_MAX)) begin
      lvl_q <= lvl_q + 1'b1;
    end
  end

  // Keep the two best entries; a later cell wins ties, so the larger id wins.
  always_comb begin
    link_d    = link_i;
    best_id_d = best_id_i;
    sec_id_d  = sec_id_i;
    if (live_q) begin
      if (!link_i.best_vld || (lvl_q >= link_i.best_lvl)) begin
        link_d.sec_vld  = link_i.best_vld;
        link_d.sec_lvl  = link_i.best_lvl;
        link_d.sec_val  = link_i.best_val;
        sec_id_d        = best_id_i;
        link_d.best_vld = 1'b1;
        link_d.best_lvl = lvl_q;
        link_d.best_val = val_q;
        best_id_d       = MY_ID;
      end else if (!link_i.sec_vld || (lvl_q >= link_i.sec_lvl)) begin
        link_d.sec_vld = 1'b1;
        link_d.sec_lvl = lvl_q;
        link_d.sec_val = val_q;
        sec_id_d       = MY_ID;
      end
      if (ctrl_i.sel) begin
        link_d.hit_live = 1'b1;
        link_d.hit_lvl  = lvl_q;
        link_d.hit_val  = val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= LINK_EMPTY;
    end else begin
      link_q <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_id_q <= best_id_d;
    sec_id_q  <= sec_id_d;
  end

  assign link_o    = link_q;
  assign best_id_o = best_id_q;
  assign sec_id_o  = sec_id_q;

endmodule

`default_nettype wire

// ===== hw/rtl/promotable_priority_table.sv =====
// Promotable priority table: a row of ENTRIES cells, each holding one entry's
// payload, level and live bit. Ids are handed out in increasing order.
// Requests arrive on req_i (mode, entry_id, item_value) as valid/ready words;
// one response word per request leaves on rsp_o with status, the result
// fields and the maximum live entry left after the operation.
// Each request is accepted, and an add or promote applied, in S_IDLE; in
// S_SCAN the running best, second best and addressed-entry record ripple
// through the cell chain one cell per cycle, and S_FINISH loads the response
// register and removes a popped entry.
// The request side takes one word at a time; it is ready whenever no word is
// in flight, even while an earlier response still waits. If the receiver
// stalls, a finished word holds in S_FINISH until the response register
// frees up. Reset empties the table and the next id returns to zero; no
// clearing pass is needed.
`default_nettype none

module promotable_priority_table #(
  parameter int unsigned ENTRIES = ppt_pkg::ENTRIES_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ppt_req_if.sink          req_i,
  ppt_rsp_if.source        rsp_o
);
  import ppt_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned NF_W  = $clog2(ENTRIES + 1);
  localparam logic [NF_W-1:0]  NF_FULL  = NF_W'(ENTRIES);
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(ENTRIES - 1);

  state_e state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             fin_go;

  logic [NF_W-1:0] next_free_q;
  logic            full;
  logic            acc;
  mode_e           req_mode;

  mode_e              op_mode_q;
  logic [ID_BITS-1:0] op_id_q;
  logic               add_ok_q;
  logic [IDX_W-1:0]   add_id_q;

  link_t            lnk   [ENTRIES];
  logic [IDX_W-1:0] bid   [ENTRIES];
  logic [IDX_W-1:0] sid   [ENTRIES];
  link_t            last;
  logic [IDX_W-1:0] last_bid;
  logic [IDX_W-1:0] last_sid;

  logic rsp_valid_q;
  rsp_t rsp_q, rsp_d;

  assign acc      = req_i.valid && req_i.ready;
  assign req_mode = mode_e'(req_i.mode);
  assign full     = (next_free_q == NF_FULL);
  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fin_go  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          fin_go  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= '0;
    end else if (acc && (req_mode == MODE_ADD) && !full) begin
      next_free_q <= next_free_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_mode_q <= req_mode;
      op_id_q   <= req_i.entry_id;
      add_ok_q  <= !full;
      add_id_q  <= next_free_q[IDX_W-1:0];
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_ctrl_t       ctrl;
    link_t            link_in;
    logic [IDX_W-1:0] bid_in;
    logic [IDX_W-1:0] sid_in;

    assign ctrl.wr      = acc && (req_mode == MODE_ADD) && !full &&
                          (int'(next_free_q) == i);
    assign ctrl.promote = acc && (req_mode == MODE_PROMOTE) &&
                          (int'(req_i.entry_id) == i);
    assign ctrl.clear   = fin_go && (op_mode_q == MODE_POP) && last.best_vld &&
                          (int'(last_bid) == i);
    assign ctrl.sel     = (int'(op_id_q) == i);

    if (i == 0) begin : g_head
      assign link_in = LINK_EMPTY;
      assign bid_in  = '0;
      assign sid_in  = '0;
    end else begin : g_body
      assign link_in = lnk[i-1];
      assign bid_in  = bid[i-1];
      assign sid_in  = sid[i-1];
    end

    ppt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_value_i (req_i.item_value),
      .link_i     (link_in),
      .best_id_i  (bid_in),
      .sec_id_i   (sid_in),
      .link_o     (lnk[i]),
      .best_id_o  (bid[i]),
      .sec_id_o   (sid[i])
    );
  end

  assign last     = lnk[ENTRIES-1];
  assign last_bid = bid[ENTRIES-1];
  assign last_sid = sid[ENTRIES-1];

  always_comb begin
    rsp_d = '0;
    rsp_d.status = ST_OK;
    case (op_mode_q)
      MODE_ADD: begin
        if (add_ok_q) begin
          rsp_d.result_id = ID_BITS'(add_id_q);
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      MODE_PROMOTE: begin
        if (last.hit_live) begin
          rsp_d.result_priority = last.hit_lvl;
        end else begin
          rsp_d.status = ST_NOT_LIVE;
        end
      end
      MODE_POP: begin
        if (last.best_vld) begin
          rsp_d.result_id       = ID_BITS'(last_bid);
          rsp_d.result_value    = last.best_val;
          rsp_d.result_priority = last.best_lvl;
        end else begin
          rsp_d.status = ST_EMPTY;
        end
      end
      default: begin
        if (last.hit_live) begin
          rsp_d.result_value    = last.hit_val;
          rsp_d.result_priority = last.hit_lvl;
          rsp_d.result_live     = 1'b1;
        end else begin
          rsp_d.status = ST_NOT_LIVE;
        end
      end
    endcase

    // After a pop the runner-up is the new maximum.
    if (op_mode_q == MODE_POP) begin
      if (last.sec_vld) begin
        rsp_d.max_present  = 1'b1;
        rsp_d.max_id       = ID_BITS'(last_sid);
        rsp_d.max_value    = last.sec_val;
        rsp_d.max_priority = last.sec_lvl;
      end
    end else if (last.best_vld) begin
      rsp_d.max_present  = 1'b1;
      rsp_d.max_id       = ID_BITS'(last_bid);
      rsp_d.max_value    = last.best_val;
      rsp_d.max_priority = last.best_lvl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fin_go) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_q.status;
  assign rsp_o.result_id       = rsp_q.result_id;
  assign rsp_o.result_value    = rsp_q.result_value;
  assign rsp_o.result_priority = rsp_q.result_priority;
  assign rsp_o.result_live     = rsp_q.result_live;
  assign rsp_o.max_present     = rsp_q.max_present;
  assign rsp_o.max_id          = rsp_q.max_id;
  assign rsp_o.max_value       = rsp_q.max_value;
  assign rsp_o.max_priority    = rsp_q.max_priority;

  a_acc_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q == S_SCAN))
    else $error("accepted word did not start a scan");

  a_next_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= NF_FULL)
    else $error("next free id beyond table size");

  a_rsp_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == S_FINISH))
    else $error("response appeared outside the finish step");

  a_best_over_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINISH) && last.best_vld && last.sec_vld) |->
      (last.best_lvl >= last.sec_lvl))
    else $error("runner-up level exceeds best level");

  a_second_needs_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINISH) && last.sec_vld) |-> last.best_vld)
    else $error("runner-up present without a best entry");

endmodule

`default_nettype wire

// ===== sim/tb_promotable_priority_table.sv =====
module tb_promotable_priority_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ppt_pkg::*;

  localparam int unsigned ENTRIES     = ENTRIES_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned MAX_REPORTS = 40;

  // Predicts the response word of every accepted request and checks the
  // responses in order against it.
  class table_scoreboard;
    logic [VALUE_BITS-1:0] slot_value [ENTRIES];
    logic [PRIO_BITS-1:0]  slot_level [ENTRIES];
    bit                    slot_live  [ENTRIES];
    int unsigned           next_id;
    rsp_t                  pending_rsp [$];
    int unsigned           errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_value[i] = '0;
        slot_level[i] = '0;
        slot_live[i]  = 1'b0;
      end
      next_id = 0;
      errors  = 0;
    endfunction

    // Highest level wins; the later slot wins a tie because of the >=.
    function int top_entry();
      int best;
      best = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_live[i] && (best < 0 || slot_level[i] >= slot_level[best])) begin
          best = i;
        end
      end
      return best;
    endfunction

    // Mostly a live entry, so that promotes and reads get past the error path.
    function logic [ID_BITS-1:0] pick_entry();
      int unsigned live_ids [$];
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_live[i]) live_ids.push_back(i);
      end
      if (live_ids.size() != 0 && $urandom_range(0, 99) < 80) begin
        return ID_BITS'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
      end
      return ID_BITS'($urandom);
    endfunction

    function void accept_request(mode_e mode, logic [ID_BITS-1:0] id,
                                 logic [VALUE_BITS-1:0] value);
      rsp_t want;
      int   top;
      want        = '0;
      want.status = ST_OK;
      case (mode)
        MODE_ADD: begin
          if (next_id >= ENTRIES) begin
            want.status = ST_FULL;
          end else begin
            slot_value[next_id] = value;
            slot_level[next_id] = '0;
            slot_live[next_id]  = 1'b1;
            want.result_id      = ID_BITS'(next_id);
            next_id++;
          end
        end
        MODE_PROMOTE: begin
          if (!slot_live[id]) begin
            want.status = ST_NOT_LIVE;
          end else begin
            if (slot_level[id] != PRIO_MAX) slot_level[id] = slot_level[id] + 1'b1;
            want.result_priority = slot_level[id];
          end
        end
        MODE_POP: begin
          top = top_entry();
          if (top < 0) begin
            want.status = ST_EMPTY;
          end else begin
            want.result_id       = ID_BITS'(top);
            want.result_value    = slot_value[top];
            want.result_priority = slot_level[top];
            slot_live[top]       = 1'b0;
            slot_value[top]      = '0;
            slot_level[top]      = '0;
          end
        end
        default: begin
          if (!slot_live[id]) begin
            want.status = ST_NOT_LIVE;
          end else begin
            want.result_value    = slot_value[id];
            want.result_priority = slot_level[id];
            want.result_live     = 1'b1;
          end
        end
      endcase
      top = top_entry();
      if (top >= 0) begin
        want.max_present  = 1'b1;
        want.max_id       = ID_BITS'(top);
        want.max_value    = slot_value[top];
        want.max_priority = slot_level[top];
      end
      pending_rsp.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: response word with none expected, expected nothing, actual %0h",
                   $time, got);
        end
        return;
      end
      want = pending_rsp.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("result_id", want.result_id, got.result_id);
      compare_field("result_value", want.result_value, got.result_value);
      compare_field("result_priority", want.result_priority, got.result_priority);
      compare_field("result_live", want.result_live, got.result_live);
      compare_field("max_present", want.max_present, got.max_present);
      compare_field("max_id", want.max_id, got.max_id);
      compare_field("max_value", want.max_value, got.max_value);
      compare_field("max_priority", want.max_priority, got.max_priority);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  bit          quiet = 1'b0;
  int unsigned cycle_count = 0;
  rsp_t        seen;

  table_scoreboard sb;

  ppt_req_if req_if ();
  ppt_rsp_if rsp_if ();

  promotable_priority_table #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("promotable_priority_table regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      seen.status          = status_e'(rsp_if.status);
      seen.result_id       = rsp_if.result_id;
      seen.result_value    = rsp_if.result_value;
      seen.result_priority = rsp_if.result_priority;
      seen.result_live     = rsp_if.result_live;
      seen.max_present     = rsp_if.max_present;
      seen.max_id          = rsp_if.max_id;
      seen.max_value       = rsp_if.max_value;
      seen.max_priority    = rsp_if.max_priority;
      sb.check_response(seen);
    end
    rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 12);
  end

  // Valid stays high from one word to the next unless an idle cycle is drawn.
  task automatic send_word(mode_e mode, logic [ID_BITS-1:0] id,
                           logic [VALUE_BITS-1:0] value);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.entry_id   <= id;
    req_if.item_value <= value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.accept_request(mode, id, value);
  endtask

  initial begin
    int unsigned sel;
    sb = new();
    rst_n             = 1'b0;
    req_if.valid      <= 1'b0;
    req_if.mode       <= MODE_ADD;
    req_if.entry_id   <= '0;
    req_if.item_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Errors on an empty table, then a level tie and a promoted winner.
    send_word(MODE_POP, 4'd0, 32'h0);
    send_word(MODE_READ, 4'd0, 32'h0);
    send_word(MODE_PROMOTE, 4'd15, 32'hFFFF_FFFF);
    send_word(MODE_ADD, 4'd15, 32'h0000_0000);
    send_word(MODE_ADD, 4'd0, 32'hFFFF_FFFF);
    send_word(MODE_POP, 4'd0, 32'h0);
    send_word(MODE_READ, 4'd1, 32'h0);
    send_word(MODE_PROMOTE, 4'd1, 32'h0);
    send_word(MODE_ADD, 4'd0, 32'hA5A5_A5A5);
    send_word(MODE_PROMOTE, 4'd0, 32'h0);
    send_word(MODE_READ, 4'd0, 32'h0);
    send_word(MODE_READ, 4'd2, 32'h0);
    send_word(MODE_POP, 4'd0, 32'h0);
    send_word(MODE_POP, 4'd0, 32'h0);
    send_word(MODE_POP, 4'd0, 32'h0);
    send_word(MODE_ADD, 4'd0, 32'h5A5A_5A5A);
    send_word(MODE_READ, 4'd3, 32'h0);

    for (int n = 0; n < 500; n++) begin
      if (n == 200) quiet <= 1'b1;
      if (n == 300) quiet <= 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        send_word(MODE_ADD, ID_BITS'($urandom), $urandom);
      end else if (sel < 8) begin
        send_word(MODE_POP, ID_BITS'($urandom), $urandom);
      end else if (sel < 55) begin
        send_word(MODE_PROMOTE, sb.pick_entry(), $urandom);
      end else begin
        send_word(MODE_READ, sb.pick_entry(), $urandom);
      end
    end

    // Use up the remaining ids, add to the full table, then drain it past empty.
    while (sb.next_id < ENTRIES) send_word(MODE_ADD, ID_BITS'($urandom), $urandom);
    send_word(MODE_ADD, ID_BITS'($urandom), $urandom);
    for (int n = 0; n <= ENTRIES; n++) begin
      send_word(MODE_POP, ID_BITS'($urandom), $urandom);
    end
    req_if.valid <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("promotable_priority_table regression: pass");
    end else begin
      $display("promotable_priority_table regression: fail");
    end
    $finish;
  end

endmodule
